[rtl/int8_quantized_add_defines.svh]
// Assertion macros used by the checker file of int8_quantized_add.
// Depends on nothing; a file that uses the macros needs signals clk and rst.
`ifndef INT8_QUANTIZED_ADD_DEFINES_SVH
`define INT8_QUANTIZED_ADD_DEFINES_SVH

// Checked on every rising edge, switched off while reset is high.
`define IQA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IQA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/iqa_pkg.sv]
// Types and constants of the int8 quantized add pipeline.
// Used by every module of the block; depends on nothing.
package iqa_pkg;

  localparam int NUM_STAGES = 5;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] MULT_RESET = 32'sh4000_0000;
  localparam logic signed [63:0] ROUND_NUDGE = 64'sh0000_0000_4000_0000;
  localparam logic [5:0] SHIFT_SIGN_ONLY = 6'd31;
  localparam logic signed [34:0] SUM_MAX = 35'sd127;
  localparam logic signed [34:0] SUM_MIN = -35'sd128;

  typedef enum logic [2:0] {
    REG_FIRST_ZP    = 3'd0,
    REG_SECOND_ZP   = 3'd1,
    REG_FIRST_MULT  = 3'd2,
    REG_FIRST_SHIFT = 3'd3,
    REG_SECOND_MULT = 3'd4,
    REG_SECOND_SHIFT = 3'd5,
    REG_OUTPUT_ZP   = 3'd6,
    REG_RELU        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [7:0] first_value;
    logic signed [7:0] second_value;
    logic              last_in;
  } in_t;

  typedef struct packed {
    logic signed [7:0] sum_value;
    logic              last_out;
  } out_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } ctl_t;

endpackage

[rtl/int8_quantized_add.sv]
// int8_quantized_add: requantizing elementwise add of two int8 streams.
// Depends on iqa_pkg, iqa_requant and iqa_combine.
//
// Input channel: item_valid, item_stall and item carry one element pair and
// its last flag per transaction. Output channel: result_valid, result_stall
// and result carry the saturated int8 sum and the copied last flag.
// Configuration: cfg_write writes cfg_data into the register that cfg_index
// selects at the clock edge; write only while no transaction is in flight.
//
// The datapath is five register stages: input requantization and left
// shift, 32x32 multiply, rounding high half, rounding right shift, then sum,
// ReLU and saturation into the output register. An accepted transaction moves
// through x1, p2, y3 and the lane result register into the output register,
// where result_valid rises; one transaction is accepted per cycle while item_stall is low.
// Each stage holds while the stage after it is full and held, so an empty
// stage anywhere still lets a new transaction in. When the receiver stalls,
// the result holds and the pipeline fills; item_stall rises once all five
// stages are full.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: zero points, shifts and ReLU cleared, both multipliers 2^30.
module int8_quantized_add (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  iqa_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_stall,
  output iqa_pkg::out_t  result,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import iqa_pkg::*;

  logic signed [7:0]  first_zp;
  logic signed [7:0]  second_zp;
  logic signed [31:0] first_mult;
  logic signed [5:0]  first_shift;
  logic signed [31:0] second_mult;
  logic signed [5:0]  second_shift;
  logic signed [7:0]  output_zp;
  logic               relu;

  logic [NUM_STAGES-1:0]   valid;
  logic [NUM_STAGES-1:0]   ready;
  logic [NUM_STAGES-2:0]   last_pipe;
  ctl_t                    ctl;
  logic signed [31:0]      first_term;
  logic signed [31:0]      second_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_zp     <= '0;
      second_zp    <= '0;
      first_mult   <= MULT_RESET;
      first_shift  <= '0;
      second_mult  <= MULT_RESET;
      second_shift <= '0;
      output_zp    <= '0;
      relu         <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_FIRST_ZP:     first_zp     <= cfg_data[7:0];
        REG_SECOND_ZP:    second_zp    <= cfg_data[7:0];
        REG_FIRST_MULT:   first_mult   <= cfg_data;
        REG_FIRST_SHIFT:  first_shift  <= cfg_data[5:0];
        REG_SECOND_MULT:  second_mult  <= cfg_data;
        REG_SECOND_SHIFT: second_shift <= cfg_data[5:0];
        REG_OUTPUT_ZP:    output_zp    <= cfg_data[7:0];
        REG_RELU:         relu         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
    ctl.en = ready;
  end

  assign item_stall   = !ready[0];
  assign result_valid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= item_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      last_pipe[0] <= item.last_in;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (ready[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  iqa_requant u_first (
    .clk    (clk),
    .ctl    (ctl),
    .value  (item.first_value),
    .zp     (first_zp),
    .mult   (first_mult),
    .shift  (first_shift),
    .result (first_term)
  );

  iqa_requant u_second (
    .clk    (clk),
    .ctl    (ctl),
    .value  (item.second_value),
    .zp     (second_zp),
    .mult   (second_mult),
    .shift  (second_shift),
    .result (second_term)
  );

  iqa_combine u_combine (
    .clk         (clk),
    .ctl         (ctl),
    .first_term  (first_term),
    .second_term (second_term),
    .zp          (output_zp),
    .relu        (relu),
    .last        (last_pipe[NUM_STAGES-2]),
    .result      (result)
  );

endmodule

[rtl/iqa_requant.sv]
// One requantization lane: zero point, saturating left shift, rounding high
// multiply and rounding right shift over four register stages. Uses iqa_pkg.
module iqa_requant (
  input  logic                clk,
  input  iqa_pkg::ctl_t       ctl,
  input  logic signed [7:0]   value,
  input  logic signed [7:0]   zp,
  input  logic signed [31:0]  mult,
  input  logic signed [5:0]   shift,
  output logic signed [31:0]  result
);
  import iqa_pkg::*;

  logic signed [8:0]  diff;
  logic signed [39:0] wide;
  logic               wide_fits;
  logic signed [31:0] x_next;
  logic signed [31:0] x1;
  logic signed [63:0] prod_next;
  logic signed [63:0] p2;
  logic               min2;
  logic signed [63:0] rounded;
  logic signed [31:0] y_next;
  logic signed [31:0] y3;
  logic [5:0]         e;
  logic               neg;
  logic signed [31:0] q;
  logic [31:0]        mask;
  logic [31:0]        rem;
  logic [31:0]        thr;
  logic               up;
  logic signed [31:0] r_next;

  always_comb begin
    diff = {value[7], value} - {zp[7], zp};
    wide = {{31{diff[8]}}, diff} <<< shift[4:0];
    wide_fits = (wide[39:31] == {9{wide[31]}});
    if (shift[5]) begin
      x_next = {{23{diff[8]}}, diff};
    end else if (wide_fits) begin
      x_next = wide[31:0];
    end else begin
      x_next = wide[39] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      x1 <= x_next;
    end
  end

  assign prod_next = 64'(x1) * 64'(mult);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      p2   <= prod_next;
      min2 <= (x1 == Q_MIN) && (mult == Q_MIN);
    end
  end

  always_comb begin
    rounded = p2 + ROUND_NUDGE;
    y_next  = min2 ? Q_MAX : rounded[62:31];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      y3 <= y_next;
    end
  end

  always_comb begin
    e    = -shift;
    neg  = y3[31];
    q    = y3 >>> e[4:0];
    mask = ~(32'hFFFF_FFFF << e[4:0]);
    rem  = y3 & mask;
    thr  = (mask >> 1) + {31'b0, neg};
    up   = rem > thr;
    if (!shift[5]) begin
      r_next = y3;
    end else if (e >= SHIFT_SIGN_ONLY) begin
      r_next = {32{neg}};
    end else begin
      r_next = q + {31'b0, up};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      result <= r_next;
    end
  end

endmodule

[rtl/iqa_combine.sv]
// Final stage: adds both lanes and the output zero point, applies ReLU and
// int8 saturation into the result register. Uses iqa_pkg.
module iqa_combine (
  input  logic                clk,
  input  iqa_pkg::ctl_t       ctl,
  input  logic signed [31:0]  first_term,
  input  logic signed [31:0]  second_term,
  input  logic signed [7:0]   zp,
  input  logic                relu,
  input  logic                last,
  output iqa_pkg::out_t       result
);
  import iqa_pkg::*;

  logic signed [34:0] zp_wide;
  logic signed [34:0] sum;
  logic signed [34:0] clamped;
  logic signed [34:0] limited;

  always_comb begin
    zp_wide = {{27{zp[7]}}, zp};
    sum = {{3{first_term[31]}}, first_term} + {{3{second_term[31]}}, second_term} + zp_wide;
    clamped = (relu && (sum < zp_wide)) ? zp_wide : sum;
    if (clamped > SUM_MAX) begin
      limited = SUM_MAX;
    end else if (clamped < SUM_MIN) begin
      limited = SUM_MIN;
    end else begin
      limited = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[NUM_STAGES-1]) begin
      result.sum_value <= limited[7:0];
      result.last_out  <= last;
    end
  end

endmodule

[rtl/iqa_checker.sv]
// Port-level checks of int8_quantized_add, bound to the top level.
// Depends on iqa_pkg and int8_quantized_add_defines.svh.
`include "int8_quantized_add_defines.svh"

module iqa_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_stall,
  input logic          result_valid,
  input logic          result_stall,
  input iqa_pkg::out_t result
);
  import iqa_pkg::*;

  logic in_taken;
  logic out_free;
  logic out_held;

  assign in_taken = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign out_held = result_valid && result_stall;

  `IQA_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

  `IQA_ASSERT(a_no_false_stall, out_free |-> !item_stall, "input stalled while output moves")

  `IQA_ASSERT(a_result_holds, out_held |=> (result_valid && $stable(result)), "result changed")

  `IQA_ASSERT(a_latency, in_taken ##1 !result_stall [*4] |=> result_valid, "result late")

endmodule

bind int8_quantized_add iqa_checker u_iqa_checker (.*);

[tb/tb_int8_quantized_add.sv]
// Self-checking testbench for int8_quantized_add: directed rows, then random phases.
// Each accepted transaction is scored against a listed sum or a bit-exact requantizing adder predictor.
// Depends on iqa_pkg and the int8_quantized_add RTL.
module tb_int8_quantized_add;
  timeunit 1ns;
  timeprecision 1ps;

  import iqa_pkg::*;

  localparam longint Q31_HI = 64'sd2147483647;
  localparam longint Q31_LO = -64'sd2147483648;
  localparam longint HALF_Q31 = 64'sd1073741824;
  localparam longint ONE_Q31 = 64'sd2147483648;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_PAIRS = 100;
  localparam int PRESSURE_PHASE = 2;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic signed [7:0]  zp_first;
    logic signed [7:0]  zp_second;
    logic signed [7:0]  zp_out;
    logic signed [31:0] mult_first;
    logic signed [31:0] mult_second;
    logic signed [5:0]  shift_first;
    logic signed [5:0]  shift_second;
    logic               relu;
  } quant_regs_t;

  typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_reg_e          reg_sel;
    logic [31:0]       data;
    logic signed [7:0] a;
    logic signed [7:0] b;
    logic              last;
    logic              known;
    logic signed [7:0] sum;
  } step_row_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  in_t         item;
  logic        result_valid;
  logic        result_stall;
  out_t        result;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  quant_regs_t regs_now;
  out_t        pending_sums[$];
  step_row_t   directed_steps[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          tx_gaps_on = 1;
  bit          rx_stalls_on = 1;
  bit          hold_off_req = 0;

  int8_quantized_add DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_q31(longint x);
    if (x > Q31_HI) return Q31_HI;
    if (x < Q31_LO) return Q31_LO;
    return x;
  endfunction

  function automatic longint high_mul_q31(longint a, longint b);
    longint p;
    longint nudge;
    if (a == Q31_LO && b == Q31_LO) return Q31_HI;
    p = a * b;
    nudge = (p >= 0) ? HALF_Q31 : 64'sd1 - HALF_Q31;
    return sat_q31((p + nudge) / ONE_Q31);
  endfunction

  function automatic longint requantize(longint x, longint m, int s);
    longint y;
    longint q;
    longint rem;
    longint thr;
    if (s >= 0) return high_mul_q31(sat_q31(x <<< s), m);
    y = high_mul_q31(x, m);
    if (-s >= 31) return (y < 0) ? -64'sd1 : 64'sd0;
    q = y >>> (-s);
    rem = y - (q <<< (-s));
    thr = (((64'sd1 <<< (-s)) - 64'sd1) >>> 1) + ((y < 0) ? 64'sd1 : 64'sd0);
    return q + ((rem > thr) ? 64'sd1 : 64'sd0);
  endfunction

  function automatic out_t predict_sum(in_t p);
    longint a;
    longint b;
    longint y;
    out_t r;
    a = longint'($signed(p.first_value)) - longint'(regs_now.zp_first);
    b = longint'($signed(p.second_value)) - longint'(regs_now.zp_second);
    y = requantize(a, longint'(regs_now.mult_first), int'(regs_now.shift_first))
      + requantize(b, longint'(regs_now.mult_second), int'(regs_now.shift_second))
      + longint'(regs_now.zp_out);
    if (regs_now.relu && y < longint'(regs_now.zp_out)) y = longint'(regs_now.zp_out);
    if (y > 64'sd127) y = 64'sd127;
    if (y < -64'sd128) y = -64'sd128;
    r.sum_value = y[7:0];
    r.last_out = p.last_in;
    return r;
  endfunction

  function automatic void add_write(cfg_reg_e r, logic [31:0] d);
    step_row_t row;
    row = '{ROW_WRITE, r, d, 8'sd0, 8'sd0, 1'b0, 1'b0, 8'sd0};
    directed_steps.push_back(row);
  endfunction

  function automatic void add_pair(logic signed [7:0] a, logic signed [7:0] b, logic last,
                                   logic known, logic signed [7:0] sum);
    step_row_t row;
    row = '{ROW_PAIR, REG_FIRST_ZP, 32'd0, a, b, last, known, sum};
    directed_steps.push_back(row);
  endfunction

  function automatic logic [31:0] pick_reg_value(cfg_reg_e r, bit wild);
    logic [31:0] v;
    case (r) inside
      REG_FIRST_MULT, REG_SECOND_MULT: begin
        if (!wild) begin
          v = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        end else begin
          case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = $urandom;
          endcase
        end
      end
      REG_FIRST_SHIFT, REG_SECOND_SHIFT: begin
        v = wild ? $urandom : 32'd1 - $urandom_range(0, 9);
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = d;
    case (r)
      REG_FIRST_ZP:     regs_now.zp_first = d[7:0];
      REG_SECOND_ZP:    regs_now.zp_second = d[7:0];
      REG_FIRST_MULT:   regs_now.mult_first = d;
      REG_FIRST_SHIFT:  regs_now.shift_first = d[5:0];
      REG_SECOND_MULT:  regs_now.mult_second = d;
      REG_SECOND_SHIFT: regs_now.shift_second = d[5:0];
      REG_OUTPUT_ZP:    regs_now.zp_out = d[7:0];
      REG_RELU:         regs_now.relu = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic wait_idle();
    item_valid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called and left right after a falling edge.
  task automatic offer_pair(in_t pkt, logic known, logic signed [7:0] sum);
    int gap;
    out_t want;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = pkt;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    if (known) begin
      want.sum_value = sum;
      want.last_out = pkt.last_in;
    end else begin
      want = predict_sum(pkt);
    end
    pending_sums.push_back(want);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  initial begin
    int run;
    int hold;
    int r;
    run = 0;
    hold = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall = 1'b1;
        hold--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
        result_stall = 1'b1;
      end else if (run > 0) begin
        run--;
      end else if (!rx_stalls_on) begin
        result_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          result_stall = 1'b0;
          run = $urandom_range(0, 6);
        end else if (r < 93) begin
          result_stall = 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          result_stall = 1'b1;
          run = $urandom_range(8, 25);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_sums.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected transaction sum %0d last %0b",
                   result.sum_value, result.last_out);
      end else begin
        want = pending_sums.pop_front();
        if (result.sum_value !== want.sum_value || result.last_out !== want.last_out) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: sum expected %0d got %0d, last expected %0b got %0b",
                     want.sum_value, result.sum_value, want.last_out, result.last_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_int8_quantized_add: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_t pkt;
    bit wild;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    regs_now = '{8'sd0, 8'sd0, 8'sd0, MULT_RESET, MULT_RESET, 6'sd0, 6'sd0, 1'b0};

    // Reset defaults: both inputs are halved with rounding and added.
    add_pair(8'sd0, 8'sd0, 1'b0, 1'b1, 8'sd0);
    add_pair(8'sd127, 8'sd127, 1'b1, 1'b1, 8'sd127);
    add_pair(-8'sd128, -8'sd128, 1'b0, 1'b1, -8'sd128);
    add_pair(8'sd127, -8'sd128, 1'b1, 1'b1, 8'sd0);
    add_pair(8'sd85, -8'sd86, 1'b0, 1'b0, 8'sd0);
    // Largest left shift and multiplier: the shifted value saturates first.
    add_write(REG_FIRST_MULT, 32'h7FFF_FFFF);
    add_write(REG_FIRST_SHIFT, 32'd31);
    add_write(REG_SECOND_MULT, 32'h7FFF_FFFF);
    add_write(REG_SECOND_SHIFT, 32'd31);
    add_pair(8'sd127, 8'sd127, 1'b1, 1'b1, 8'sd127);
    add_pair(-8'sd128, -8'sd128, 1'b0, 1'b1, -8'sd128);
    add_pair(8'sd1, -8'sd1, 1'b0, 1'b0, 8'sd0);
    add_pair(8'sd0, 8'sd0, 1'b1, 1'b1, 8'sd0);
    // Most negative times most negative gives the largest positive value.
    add_write(REG_FIRST_MULT, 32'h8000_0000);
    add_write(REG_SECOND_MULT, 32'h0000_0000);
    add_pair(-8'sd128, 8'sd5, 1'b0, 1'b1, 8'sd127);
    add_pair(8'sd127, -8'sd7, 1'b1, 1'b1, -8'sd128);
    // Right shifts of 31 and 32 leave only the sign.
    add_write(REG_FIRST_MULT, 32'h4000_0000);
    add_write(REG_FIRST_SHIFT, 32'h0000_0021);
    add_write(REG_SECOND_MULT, 32'h7FFF_FFFF);
    add_write(REG_SECOND_SHIFT, 32'h0000_0020);
    add_pair(-8'sd128, -8'sd128, 1'b0, 1'b1, -8'sd2);
    add_pair(8'sd127, 8'sd127, 1'b0, 1'b1, 8'sd0);
    add_pair(-8'sd1, 8'sd1, 1'b1, 1'b0, 8'sd0);
    // Zero point extremes with ReLU clamping at the output zero point.
    add_write(REG_FIRST_SHIFT, 32'd0);
    add_write(REG_SECOND_SHIFT, 32'd0);
    add_write(REG_SECOND_MULT, 32'h4000_0000);
    add_write(REG_FIRST_ZP, 32'h0000_007F);
    add_write(REG_SECOND_ZP, 32'h0000_0080);
    add_write(REG_OUTPUT_ZP, 32'h0000_007F);
    add_write(REG_RELU, 32'd1);
    add_pair(-8'sd128, 8'sd127, 1'b0, 1'b1, 8'sd127);
    add_pair(-8'sd128, -8'sd128, 1'b1, 1'b1, 8'sd127);
    add_write(REG_OUTPUT_ZP, 32'h0000_0080);
    add_pair(-8'sd128, 8'sd127, 1'b0, 1'b0, 8'sd0);
    add_pair(8'sd0, -8'sd128, 1'b1, 1'b0, 8'sd0);
    add_write(REG_OUTPUT_ZP, 32'hFFFF_FFFD);
    add_pair(-8'sd20, 8'sd30, 1'b0, 1'b0, 8'sd0);
    add_pair(-8'sd100, -8'sd100, 1'b0, 1'b0, 8'sd0);
    add_write(REG_RELU, 32'd0);
    add_pair(-8'sd100, -8'sd100, 1'b1, 1'b0, 8'sd0);

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_steps[i].reg_sel, directed_steps[i].data);
      end else begin
        pkt.first_value = directed_steps[i].a;
        pkt.second_value = directed_steps[i].b;
        pkt.last_in = directed_steps[i].last;
        offer_pair(pkt, directed_steps[i].known, directed_steps[i].sum);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      tx_gaps_on = (ph % 3 != 1);
      rx_stalls_on = (ph % 4 != 2);
      wild = ($urandom_range(0, 3) == 0) && (ph != PRESSURE_PHASE);
      for (int k = 0; k < 8; k++)
        write_reg(cfg_reg_e'(k), pick_reg_value(cfg_reg_e'(k), wild));
      if (ph == PRESSURE_PHASE) begin
        tx_gaps_on = 1'b0;
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        pkt.first_value = $urandom;
        pkt.second_value = $urandom;
        pkt.last_in = (n == PHASE_PAIRS - 1) || ($urandom_range(0, 15) == 0);
        offer_pair(pkt, 1'b0, 8'sd0);
      end
    end

    item_valid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_int8_quantized_add: PASS");
    end else begin
      $display("tb_int8_quantized_add: FAIL");
    end
    $finish;
  end

endmodule
